// ===== rtl/tlpc_pkg.sv =====
// Shared types, constants and lamp decoding for the traffic light phase controller.
package tlpc_pkg;

   localparam int PhaseW            = 5;
   localparam int PhaseFieldW       = 4;
   localparam int TickW             = 16;
   localparam int LampW             = 2;
   localparam int HeadW             = 3;
   localparam int PhaseCountDefault = 8;

   localparam logic [TickW-1:0] PhaseTicksReset = 16'd2000;

   localparam logic [LampW-1:0] LampRed   = 2'd0;
   localparam logic [LampW-1:0] LampGreen = 2'd1;
   localparam logic [LampW-1:0] LampAmber = 2'd2;

   typedef logic [PhaseW-1:0] phase_type;

   typedef struct packed {
      logic                   emergency;
      logic [PhaseFieldW-1:0] target_phase;
   } req_type;

   typedef struct packed {
      logic [PhaseFieldW-1:0] phase;
      logic [LampW-1:0]       head_one;
      logic [LampW-1:0]       head_two;
      logic [LampW-1:0]       head_three;
      logic [LampW-1:0]       head_four;
      logic                   preempting;
   } rsp_type;

   typedef struct packed {
      phase_type        shown;
      phase_type        cycle;
      logic [TickW-1:0] ticks;
      logic             active;
   } state_type;

   // Head h is green in phase 2h-1 and amber in phase 2h, red otherwise.
   function automatic logic [LampW-1:0] head_lamp(phase_type shown, logic [HeadW-1:0] head);
      phase_type amber_phase;
      phase_type green_phase;
      logic [LampW-1:0] lamp;
      amber_phase = phase_type'({head, 1'b0});
      green_phase = amber_phase - phase_type'(1);
      if (shown == green_phase) begin
         lamp = LampGreen;
      end else if (shown == amber_phase) begin
         lamp = LampAmber;
      end else begin
         lamp = LampRed;
      end
      return lamp;
   endfunction

endpackage

// ===== rtl/tlpc_req_if.sv =====
// Tick request channel carrying the emergency request and target phase.
interface tlpc_req_if;
   import tlpc_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tlpc_rsp_if.sv =====
// Result channel carrying the shown phase and the four head lamps.
interface tlpc_rsp_if;
   import tlpc_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/tlpc_step.sv =====
// Next-state logic for one tick: normal cycling, emergency hold, start and wait.
module tlpc_step #(
   parameter int PHASE_COUNT = tlpc_pkg::PhaseCountDefault
) (
   input  tlpc_pkg::state_type        state,
   input  tlpc_pkg::req_type          req,
   input  logic [tlpc_pkg::TickW-1:0] phase_ticks,
   output tlpc_pkg::state_type        next_state
);
   import tlpc_pkg::*;

   localparam phase_type LastPhase = phase_type'(PHASE_COUNT);

   logic [TickW-1:0] period;
   logic [TickW-1:0] base_ticks;
   logic [TickW:0]   ticks_plus;
   logic             period_done;
   phase_type        target;
   logic             target_ok;
   phase_type        cycle_next;

   always_comb begin
      period = (phase_ticks == '0) ? TickW'(1) : phase_ticks;
      target = phase_type'(req.target_phase);
      target_ok = (target != '0) && (target <= LastPhase);

      // A normal tick that ends a transition restarts the count from zero.
      base_ticks = (state.active && !(req.emergency && target_ok)) ? '0 : state.ticks;
      ticks_plus = {1'b0, base_ticks} + (TickW+1)'(1);
      period_done = ticks_plus >= {1'b0, period};
      cycle_next = (state.cycle >= LastPhase) ? phase_type'(1) : state.cycle + phase_type'(1);

      next_state = state;
      if (!req.emergency || !target_ok) begin
         next_state.active = 1'b0;
         if (period_done) begin
            next_state.ticks = '0;
            next_state.cycle = cycle_next;
            next_state.shown = cycle_next;
         end else begin
            next_state.ticks = ticks_plus[TickW-1:0];
            next_state.shown = state.cycle;
         end
      end else if (target == state.shown) begin
         next_state.cycle  = state.shown;
         next_state.active = 1'b0;
         next_state.ticks  = '0;
      end else if (!state.active) begin
         // A green phase drops to its amber; the last phase has no amber after it.
         if (state.shown[0] && (state.shown < LastPhase)) begin
            next_state.shown = state.shown + phase_type'(1);
         end
         next_state.active = 1'b1;
         next_state.ticks  = '0;
      end else begin
         if (period_done) begin
            next_state.shown  = target;
            next_state.active = 1'b0;
            next_state.ticks  = '0;
         end else begin
            next_state.ticks = ticks_plus[TickW-1:0];
         end
      end
   end

endmodule

// ===== rtl/traffic_light_phase_controller.sv =====
// Top level of the traffic light phase controller with emergency preemption.
//
//   Channel   Dir   Payload                                        Transfer when
//   req_chan  in    emergency, target_phase                        valid && ready
//   rsp_chan  out   phase, head_one..head_four, preempting         valid && ready
//   csr_*     in    phase_ticks (16 bit)                           csr_wr_en high
//
// One tick is taken per clock cycle; its result appears in the output register
// on the next cycle. The state update and lamp decoding sit between the state
// registers and the output register. A stalled result holds in the output
// register, and a new tick is taken in the same cycle the held result is
// transferred. Synchronous reset returns to phase 1 with phase_ticks at 2000.
module traffic_light_phase_controller #(
   parameter int PHASE_COUNT = tlpc_pkg::PhaseCountDefault
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [tlpc_pkg::TickW-1:0] csr_wr_data,
   tlpc_req_if.sink                   req_chan,
   tlpc_rsp_if.source                 rsp_chan
);
   import tlpc_pkg::*;

   localparam phase_type LastPhase = phase_type'(PHASE_COUNT);

   state_type        state_ff;
   state_type        state_in;
   logic [TickW-1:0] ticks_cfg_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_payload_ff;
   rsp_type          rsp_payload_in;
   logic             req_accept;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   tlpc_step #(
      .PHASE_COUNT (PHASE_COUNT)
   ) u_step (
      .state       (state_ff),
      .req         (req_chan.payload),
      .phase_ticks (ticks_cfg_ff),
      .next_state  (state_in)
   );

   always_comb begin
      rsp_payload_in.phase      = state_in.shown[PhaseFieldW-1:0];
      rsp_payload_in.head_one   = head_lamp(state_in.shown, HeadW'(1));
      rsp_payload_in.head_two   = head_lamp(state_in.shown, HeadW'(2));
      rsp_payload_in.head_three = head_lamp(state_in.shown, HeadW'(3));
      rsp_payload_in.head_four  = head_lamp(state_in.shown, HeadW'(4));
      rsp_payload_in.preempting = state_in.active;
      rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.shown  <= phase_type'(1);
         state_ff.cycle  <= phase_type'(1);
         state_ff.ticks  <= '0;
         state_ff.active <= 1'b0;
         ticks_cfg_ff    <= PhaseTicksReset;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (csr_wr_en) begin
            ticks_cfg_ff <= csr_wr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

`ifndef NO_ASSERTIONS
   // During a transition the shown phase is an amber phase or the last phase.
   a_transition_amber: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (!state_ff.shown[0] || state_ff.shown == LastPhase))
      else $error("transition active on a green phase other than the last");

   a_shown_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.shown != '0) && (state_ff.shown <= LastPhase))
      else $error("shown phase out of range");

   a_cycle_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.cycle != '0) && (state_ff.cycle <= LastPhase))
      else $error("cycle phase out of range");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("state changed without a tick transfer");

   a_normal_ends_transition: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_chan.payload.emergency |=> !state_ff.active && !rsp_chan.payload.preempting)
      else $error("normal tick left a transition active");
`endif

endmodule
